### design/lfp_pkg.sv
package lfp_pkg;

	// Fixed header layout: meta length, body length, magic, version.
	localparam int HEADER_BYTES = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_META = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 2'd3;

	localparam logic [1:0] KIND_META  = 2'd0;
	localparam logic [1:0] KIND_BODY  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       section_last;
		logic       frame_last;
	} res_t;

	// Front to queue: one result per accepted item, when push is set.
	typedef struct packed {
		logic push;
		res_t res;
	} push_t;

endpackage

### design/length_prefixed_frame_parser.sv
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   in_byte
// result    out        out_valid/out_stall out_kind, out_byte, section_last, frame_last
// config    in         cfg_we              cfg_index, cfg_data
//
// One byte is taken per clock while in_stall is low; each byte leaves at
// most one result, which is written into the result queue and leaves from there.
// The front section counts header and section bytes and does the header
// checks in the cycle of the last header byte; a small result queue
// (QUEUE_DEPTH entries) parts it from the output side.
// in_stall rises only when the queue is full, i.e. after out_stall has
// held back QUEUE_DEPTH results; bytes that make no result still need a
// free queue slot to be taken.
// Reset clears the queue, returns to header collection and loads the
// register defaults; a protocol error holds the block dropping bytes
// until the next reset.
module length_prefixed_frame_parser #(
	parameter int QUEUE_DEPTH = lfp_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      in_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      out_kind,
	output logic [7:0]                      out_byte,
	output logic                            section_last,
	output logic                            frame_last,
	input  logic                            cfg_we,
	input  logic [lfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lfp_pkg::push_t push;
	lfp_pkg::res_t  head;
	logic           full;

	// Front: header collection, checks, section counting, result tagging.
	lfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.full      (full),
		.in_byte   (in_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push_o    (push)
	);

	// Back: result queue that absorbs output stalls.
	lfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_i    (push),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// Hold input while no queue slot is free.
	assign in_stall     = full;
	assign out_kind     = head.kind;
	assign out_byte     = head.data;
	assign section_last = head.section_last;
	assign frame_last   = head.frame_last;

endmodule

### design/lfp_front.sv
module lfp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            full,
	input  logic [7:0]                      in_byte,
	input  logic                            cfg_we,
	input  logic [lfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lfp_pkg::push_t                  push_o
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_META   = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;
	localparam logic [1:0] PH_ERROR  = 2'd3;

	localparam logic [3:0] HDR_LAST = 4'(lfp_pkg::HEADER_BYTES - 1);

	logic [15:0] exp_magic_q;
	logic [15:0] exp_version_q;
	logic [31:0] max_meta_q;
	logic [31:0] max_body_q;

	logic [1:0]  phase_q, phase_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] meta_len_q, meta_len_d;
	logic [31:0] body_len_q, body_len_d;
	logic [15:0] magic_q, magic_d;
	logic [15:0] version_q, version_d;
	logic [31:0] left_q, left_d;

	logic           accept;
	logic           last;
	logic           bad;
	logic [15:0]    version_full;
	lfp_pkg::push_t push_d;

	assign accept       = in_valid && !full;
	assign version_full = {version_q[7:0], in_byte};
	assign last         = (left_q == 32'd1);
	assign bad          = (magic_q != exp_magic_q) || (version_full != exp_version_q) ||
	                      (meta_len_q > max_meta_q) || (body_len_q > max_body_q);

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		meta_len_d = meta_len_q;
		body_len_d = body_len_q;
		magic_d    = magic_q;
		version_d  = version_q;
		left_d     = left_q;
		push_d     = '0;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q < 4'd4) begin
					meta_len_d = {meta_len_q[23:0], in_byte};
				end else if (hdr_cnt_q < 4'd8) begin
					body_len_d = {body_len_q[23:0], in_byte};
				end else if (hdr_cnt_q < 4'd10) begin
					magic_d = {magic_q[7:0], in_byte};
				end else begin
					version_d = version_full;
				end
				if (hdr_cnt_q != HDR_LAST) begin
					hdr_cnt_d = hdr_cnt_q + 4'd1;
				end else begin
					hdr_cnt_d = 4'd0;
					if (bad) begin
						phase_d                 = PH_ERROR;
						push_d.push             = 1'b1;
						push_d.res.kind         = lfp_pkg::KIND_ERROR;
						push_d.res.frame_last   = 1'b1;
					end else if (meta_len_q == 32'd0 && body_len_q == 32'd0) begin
						push_d.push             = 1'b1;
						push_d.res.kind         = lfp_pkg::KIND_EMPTY;
						push_d.res.frame_last   = 1'b1;
					end else if (meta_len_q != 32'd0) begin
						phase_d = PH_META;
						left_d  = meta_len_q;
					end else begin
						phase_d = PH_BODY;
						left_d  = body_len_q;
					end
				end
			end
			PH_META: begin
				push_d.push             = 1'b1;
				push_d.res.kind         = lfp_pkg::KIND_META;
				push_d.res.data         = in_byte;
				push_d.res.section_last = last;
				push_d.res.frame_last   = last && (body_len_q == 32'd0);
				left_d                  = left_q - 32'd1;
				if (last) begin
					if (body_len_q != 32'd0) begin
						phase_d = PH_BODY;
						left_d  = body_len_q;
					end else begin
						phase_d = PH_HEADER;
					end
				end
			end
			PH_BODY: begin
				push_d.push             = 1'b1;
				push_d.res.kind         = lfp_pkg::KIND_BODY;
				push_d.res.data         = in_byte;
				push_d.res.section_last = last;
				push_d.res.frame_last   = last;
				left_d                  = left_q - 32'd1;
				if (last) begin
					phase_d = PH_HEADER;
				end
			end
			PH_ERROR: begin
				// drop everything until reset
			end
			default: begin
			end
		endcase
		if (!accept) begin
			push_d.push = 1'b0;
		end
	end

	assign push_o = push_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 4'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_len_q <= meta_len_d;
			body_len_q <= body_len_d;
			magic_q    <= magic_d;
			version_q  <= version_d;
			left_q     <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_magic_q   <= 16'd0;
			exp_version_q <= 16'd0;
			max_meta_q    <= 32'hFFFF_FFFF;
			max_body_q    <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfp_pkg::CFG_MAGIC:    exp_magic_q   <= cfg_data[15:0];
				lfp_pkg::CFG_VERSION:  exp_version_q <= cfg_data[15:0];
				lfp_pkg::CFG_MAX_META: max_meta_q    <= cfg_data;
				lfp_pkg::CFG_MAX_BODY: max_body_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	a_error_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) |-> !push_d.push)
		else $error("push while in error phase");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(push_d.push && push_d.res.kind == lfp_pkg::KIND_ERROR) |=> (phase_q == PH_ERROR))
		else $error("error result without entering error phase");

	a_section_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_META || phase_q == PH_BODY) |-> (left_q != 32'd0))
		else $error("section active with no bytes left");

endmodule

### design/lfp_queue.sv
module lfp_queue #(
	parameter int DEPTH = lfp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lfp_pkg::push_t push_i,
	output logic           full,
	output logic           out_valid,
	input  logic           out_stall,
	output lfp_pkg::res_t  head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_C  = (AW + 1)'(DEPTH);

	lfp_pkg::res_t entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          push;
	logic          pop;

	assign full      = (count_q == DEPTH_C);
	assign out_valid = (count_q != '0);
	assign push      = push_i.push;
	assign pop       = out_valid && !out_stall;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_i.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count beyond depth");

	a_swap_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pop) |=> (count_q == $past(count_q)))
		else $error("count moved on simultaneous push and pop");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

	// Phases of the deframer as the testbench tracks them.
	typedef enum logic [1:0] {
		PH_HDR,
		PH_META,
		PH_BODY,
		PH_DEAD
	} deframe_phase_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       section_last;
	logic       frame_last;
	logic                           cfg_we    = 1'b0;
	logic [lfp_pkg::CFG_IDX_W-1:0]  cfg_index = lfp_pkg::CFG_MAGIC;
	logic [lfp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// Register copies, loaded with their reset values.
	logic [15:0] cfg_magic    = 16'h0000;
	logic [15:0] cfg_version  = 16'h0000;
	logic [31:0] cfg_meta_max = 32'hFFFF_FFFF;
	logic [31:0] cfg_body_max = 32'hFFFF_FFFF;

	// Deframer state as predicted from the accepted bytes.
	deframe_phase_t p_phase     = PH_HDR;
	int             p_hdr_idx   = 0;
	logic [31:0]    p_meta_len  = '0;
	logic [31:0]    p_body_len  = '0;
	logic [15:0]    p_magic     = '0;
	logic [15:0]    p_version   = '0;
	logic [31:0]    p_remaining = '0;

	// Results still owed by the block, oldest first.
	lfp_pkg::res_t pending_results [$];

	// Idling knobs: clear them to run a stretch at full rate.
	bit tx_gap_on   = 1'b1;
	bit rx_stall_on = 1'b1;

	int n_errors   = 0;
	int n_bytes    = 0;
	int n_frames   = 0;
	int n_results  = 0;
	int n_settings = 0;

	lfp_pkg::res_t got;
	lfp_pkg::res_t want;

	length_prefixed_frame_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.section_last(section_last),
		.frame_last  (frame_last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string what);
		n_errors++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic lfp_pkg::res_t result_of(input logic [1:0] kind, input logic [7:0] data,
	                                            input logic slast, input logic flast);
		lfp_pkg::res_t r;
		r.kind         = kind;
		r.data         = data;
		r.section_last = slast;
		r.frame_last   = flast;
		return r;
	endfunction

	// Advance the predicted deframer by one accepted byte and queue what it emits.
	task automatic deframe_step(input logic [7:0] b);
		logic fin;
		case (p_phase)
			PH_HDR: begin
				// Header is big-endian: meta length, body length, magic, version.
				if (p_hdr_idx < 4)
					p_meta_len = {p_meta_len[23:0], b};
				else if (p_hdr_idx < 8)
					p_body_len = {p_body_len[23:0], b};
				else if (p_hdr_idx < 10)
					p_magic = {p_magic[7:0], b};
				else
					p_version = {p_version[7:0], b};
				if (p_hdr_idx != lfp_pkg::HEADER_BYTES - 1) begin
					p_hdr_idx++;
				end else begin
					p_hdr_idx = 0;
					// Check the header against the registers as they stand now.
					if (p_magic != cfg_magic || p_version != cfg_version ||
					    p_meta_len > cfg_meta_max || p_body_len > cfg_body_max) begin
						p_phase = PH_DEAD;
						pending_results.push_back(result_of(lfp_pkg::KIND_ERROR, 8'h00,
						                                    1'b0, 1'b1));
					end else if (p_meta_len == 0 && p_body_len == 0) begin
						pending_results.push_back(result_of(lfp_pkg::KIND_EMPTY, 8'h00,
						                                    1'b0, 1'b1));
					end else if (p_meta_len != 0) begin
						p_phase     = PH_META;
						p_remaining = p_meta_len;
					end else begin
						p_phase     = PH_BODY;
						p_remaining = p_body_len;
					end
				end
			end
			PH_META: begin
				p_remaining--;
				fin = (p_remaining == 0);
				// With no body the last metadata byte also closes the frame.
				pending_results.push_back(result_of(lfp_pkg::KIND_META, b, fin,
				                                    fin && p_body_len == 0));
				if (fin) begin
					if (p_body_len != 0) begin
						p_phase     = PH_BODY;
						p_remaining = p_body_len;
					end else begin
						p_phase = PH_HDR;
					end
				end
			end
			PH_BODY: begin
				p_remaining--;
				fin = (p_remaining == 0);
				pending_results.push_back(result_of(lfp_pkg::KIND_BODY, b, fin, fin));
				if (fin)
					p_phase = PH_HDR;
			end
			default: ; // after a protocol error every byte is dropped
		endcase
	endtask

	// Offer one byte and hold it until taken. Valid stays high on return, so that
	// a following byte can go out on the very next edge; release_input drops it.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_gap_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		deframe_step(b);
		n_bytes++;
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	task automatic send_header(input logic [31:0] mlen, input logic [31:0] blen,
	                           input logic [15:0] magic, input logic [15:0] version);
		logic [95:0] hdr;
		hdr = {mlen, blen, magic, version};
		for (int i = 0; i < lfp_pkg::HEADER_BYTES; i++)
			send_byte(hdr[95 - 8 * i -: 8]);
		n_frames++;
	endtask

	task automatic send_frame(input logic [31:0] mlen, input logic [31:0] blen,
	                          input logic [15:0] magic, input logic [15:0] version);
		send_header(mlen, blen, magic, version);
		for (int i = 0; i < int'(mlen + blen); i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// Wait until every owed result has come back, then let the block settle so
	// that trailing header bytes are fully absorbed before the next register write.
	task automatic wait_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; the unused upper half of
	// the magic and version writes carries random junk that must be ignored.
	task automatic program_regs(input logic [15:0] magic, input logic [15:0] version,
	                            input logic [31:0] meta_max, input logic [31:0] body_max);
		logic [lfp_pkg::CFG_IDX_W-1:0]  idx  [4];
		logic [lfp_pkg::CFG_DATA_W-1:0] vals [4];
		idx  = '{lfp_pkg::CFG_MAGIC, lfp_pkg::CFG_VERSION, lfp_pkg::CFG_MAX_META,
		         lfp_pkg::CFG_MAX_BODY};
		vals = '{{16'($urandom), magic}, {16'($urandom), version}, meta_max, body_max};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we       <= 1'b0;
		cfg_magic    = magic;
		cfg_version  = version;
		cfg_meta_max = meta_max;
		cfg_body_max = body_max;
		n_settings++;
	endtask

	// Pick a section length that the limit accepts, small enough to finish,
	// with zero and the limit itself showing up often.
	function automatic logic [31:0] pick_len(input logic [31:0] lim);
		logic [31:0] cap;
		cap = (lim > 32'd20) ? 32'd20 : lim;
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 1) ? cap : 32'd0;
		return $urandom_range(0, cap);
	endfunction

	// Receiver: stall in bursts, mostly short, now and then long.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else if (rx_stall_on && $urandom_range(0, 99) < 15)
				hold = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
				                                    : $urandom_range(4, 24);
			out_stall <= (hold > 0);
		end
	end

	// Check every taken result against the oldest owed one, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			got = result_of(out_kind, out_byte, section_last, frame_last);
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d byte %02h",
				                        got.kind, got.data));
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind)
					flag_mismatch($sformatf("out_kind %0d, want %0d", got.kind, want.kind));
				if (got.data !== want.data)
					flag_mismatch($sformatf("out_byte %02h, want %02h", got.data, want.data));
				if (got.section_last !== want.section_last)
					flag_mismatch($sformatf("section_last %b, want %b",
					                        got.section_last, want.section_last));
				if (got.frame_last !== want.frame_last)
					flag_mismatch($sformatf("frame_last %b, want %b",
					                        got.frame_last, want.frame_last));
			end
		end
	end

	// Run on the reset register values: zero magic and version, no length limit.
	task automatic test_reset_values();
		send_header(32'd0, 32'd0, 16'h0000, 16'h0000);
		send_header(32'd1, 32'd1, 16'h0000, 16'h0000);
		send_byte(8'hFF);
		send_byte(8'h00);
		release_input();
		wait_idle();
	endtask

	// Lengths right at the limits, each section missing in turn, and an empty frame.
	task automatic test_sections_at_limits();
		program_regs(16'hFFFF, 16'hFFFF, 32'd2, 32'd1);
		send_header(32'd2, 32'd0, 16'hFFFF, 16'hFFFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_header(32'd0, 32'd1, 16'hFFFF, 16'hFFFF);
		send_byte(8'h5A);
		send_frame(32'd2, 32'd1, 16'hFFFF, 16'hFFFF);
		send_header(32'd0, 32'd0, 16'hFFFF, 16'hFFFF);
		release_input();
		wait_idle();
	endtask

	// Both limits at zero: only empty frames pass. Send them back to back.
	task automatic test_zero_limits();
		tx_gap_on   = 1'b0;
		rx_stall_on = 1'b0;
		program_regs(16'($urandom), 16'($urandom), 32'd0, 32'd0);
		send_header(32'd0, 32'd0, cfg_magic, cfg_version);
		send_header(32'd0, 32'd0, cfg_magic, cfg_version);
		release_input();
		wait_idle();
		tx_gap_on   = 1'b1;
		rx_stall_on = 1'b1;
	endtask

	// Well-formed frames with random content, a few frames per register setting.
	task automatic test_random_traffic();
		int          start;
		int          s;
		logic [31:0] mmax;
		logic [31:0] bmax;
		start = n_bytes;
		s     = 0;
		while (n_bytes - start < 600) begin
			case (s % 4)
				0: begin
					mmax = 32'hFFFF_FFFF;
					bmax = 32'hFFFF_FFFF;
				end
				1: begin
					mmax = $urandom_range(1, 12);
					bmax = $urandom_range(1, 12);
				end
				2: begin
					mmax = 32'd0;
					bmax = $urandom_range(0, 30);
				end
				default: begin
					mmax = $urandom;
					bmax = 32'd0;
				end
			endcase
			program_regs(16'($urandom), 16'($urandom), mmax, bmax);
			// Every so often run a setting with no idling at all on one side or both.
			tx_gap_on   = ($urandom_range(0, 3) != 0);
			rx_stall_on = ($urandom_range(0, 3) != 0);
			repeat (5)
				send_frame(pick_len(mmax), pick_len(bmax), cfg_magic, cfg_version);
			release_input();
			wait_idle();
			s++;
		end
		tx_gap_on   = 1'b1;
		rx_stall_on = 1'b1;
	endtask

	// Break one header check; the block must report it once and then drop
	// everything, so this has to be the last traffic of the run.
	task automatic test_protocol_error();
		logic [15:0] hm;
		logic [15:0] hv;
		logic [31:0] ml;
		logic [31:0] bl;
		program_regs(16'($urandom), 16'($urandom), $urandom_range(0, 1000),
		             $urandom_range(0, 1000));
		hm = cfg_magic;
		hv = cfg_version;
		ml = pick_len(cfg_meta_max);
		bl = pick_len(cfg_body_max);
		case ($urandom_range(0, 3))
			0: hm = hm ^ 16'($urandom_range(1, 65535));
			1: hv = hv ^ 16'($urandom_range(1, 65535));
			2: ml = $urandom_range(0, 1) ? 32'hFFFF_FFFF : cfg_meta_max + 1;
			default: bl = $urandom_range(0, 1) ? 32'hFFFF_FFFF : cfg_body_max + 1;
		endcase
		send_header(ml, bl, hm, hv);
		// Follow with bytes that would parse as a fine header; all are dropped.
		send_header(32'd1, 32'd0, cfg_magic, cfg_version);
		send_byte(8'hFF);
		repeat (16)
			send_byte(8'($urandom_range(0, 255)));
		release_input();
		wait_idle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_sections_at_limits();
		test_zero_limits();
		test_random_traffic();
		test_protocol_error();

		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d frames across %0d register settings,",
		         n_bytes, n_frames, n_settings);
		$display("checked %0d results, ending on a protocol error and dropped bytes.",
		         n_results);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(5_000_000);
		$display("Timeout with %0d results still owed", pending_results.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
